/* sv/idwt53_pkg.sv */
// ----------------------------------------------------------------------------
// idwt53_pkg
// Shared types, constants and lifting arithmetic for the inverse 5/3 tile
// wavelet transform.
// ----------------------------------------------------------------------------
package idwt53_pkg;

    localparam int TILE_SIDE = 64;
    localparam int AREA      = TILE_SIDE * TILE_SIDE;
    localparam int AW        = $clog2(AREA);
    localparam int CW        = $clog2(TILE_SIDE);
    localparam int LOG_W0    = $clog2(TILE_SIDE / 8);
    localparam int LEVELS    = 3;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_TRANSFORM = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDATA,
        ST_LINE,
        ST_RD_L,
        ST_RD_H,
        ST_CALC,
        ST_WR_O,
        ST_WR_LAST,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_H1,
        PH_H2,
        PH_V
    } phase_t;

    function automatic logic [15:0] asr1(input logic [15:0] v);
        asr1 = {v[15], v[15:1]};
    endfunction

    function automatic logic [15:0] lift_even(input logic [15:0] l,
                                              input logic [15:0] hp,
                                              input logic [15:0] hc);
        lift_even = l - asr1(hp + hc + 16'd1);
    endfunction

    function automatic logic [15:0] lift_odd(input logic [15:0] h,
                                             input logic [15:0] ea,
                                             input logic [15:0] eb);
        lift_odd = {h[14:0], 1'b0} + asr1(ea + eb);
    endfunction

endpackage

/* sv/tile_inverse_dwt53_three_level.sv */
// ----------------------------------------------------------------------------
// tile_inverse_dwt53_three_level
// Three-level inverse 5/3 lifting wavelet transform over a square tile.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid/in_ready) with an opcode,
// a position and a coefficient. A load writes the coefficient into the tile
// store and gives no result. A read returns the stored sample on the output
// channel (out_valid/out_ready) through the read-data state and the output
// register. A transform rebuilds the tile level by level, smallest level
// first; each level runs two horizontal passes into the scratch store and
// one vertical pass back into the tile. Every sample takes two reads on the
// single source port, then the even write and the odd write on the
// destination port. A transform's result carries kind 1 and sample 0.
// The block takes one read or transform at a time; loads are taken while a
// result waits. If the receiver stalls, the result is held in the output
// register. Reset clears the control state only; the stores hold no
// defined contents until written.
// ----------------------------------------------------------------------------
module tile_inverse_dwt53_three_level
    import idwt53_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [11:0] position,
    input  logic [15:0] coefficient,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sample,
    output logic        kind
);

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [1:0]    lvl_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] line_reg;
    logic [AW-1:0] la_reg, ha_reg, ea_reg, oa_reg, ls_reg, ds_reg;
    logic [15:0]   l_reg, hcur_reg, hprev_reg, ecur_reg, eprev_reg;
    logic          out_valid_reg;
    logic [15:0]   sample_reg;
    logic          kind_reg;
    logic          pos_ok_reg;

    logic [AW-1:0] tile_addr, scr_addr;
    logic          tile_we, scr_we;
    logic [15:0]   tile_wdata, scr_wdata, tile_rdata, scr_rdata;

    logic          accept;
    logic          pos_ok;
    logic [AW-1:0] pos_aw;
    logic [AW-1:0] one_aw, w_aw, q_aw, base_aw, tw_aw, line_aw, y_off, y_off2;
    logic [CW-1:0] n_last, line_last;
    logic [15:0]   src_data, hp, even_val, odd_val, last_val;
    logic [AW-1:0] dst_addr;
    logic          dst_we;
    logic [15:0]   dst_data;

    assign accept = in_valid && in_ready;
    assign pos_aw = AW'(position);
    assign pos_ok = (32'(position) < AREA);

    assign one_aw  = {{(AW-1){1'b0}}, 1'b1};
    assign w_aw    = one_aw << (LOG_W0 + int'(lvl_reg));
    assign q_aw    = one_aw << (2 * (LOG_W0 + int'(lvl_reg)));
    assign base_aw = {AW{1'b0}} - (q_aw << 2);
    assign tw_aw   = w_aw << 1;
    assign line_aw = AW'(line_reg);
    assign y_off   = line_aw << (LOG_W0 + int'(lvl_reg));
    assign y_off2  = y_off << 1;
    assign n_last  = w_aw[CW-1:0] - CW'(1);
    assign line_last = (phase_reg == PH_V) ? (tw_aw[CW-1:0] - CW'(1)) : n_last;

    assign src_data = (phase_reg == PH_V) ? scr_rdata : tile_rdata;
    assign hp       = (n_reg == '0) ? src_data : hcur_reg;
    assign even_val = lift_even(l_reg, hp, src_data);
    assign odd_val  = lift_odd(hprev_reg, eprev_reg, ecur_reg);
    assign last_val = lift_odd(hcur_reg, ecur_reg, ecur_reg);

    // Ready in idle only: loads and no-ops pass while a result waits; reads and transforms need it free.
    assign in_ready = (state_reg == ST_IDLE) &&
                      (!out_valid_reg || opcode == OP_LOAD || opcode == OP_NONE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && opcode == OP_READ)
                begin
                    state_next = ST_RDATA;
                end
                else if (accept && opcode == OP_TRANSFORM)
                begin
                    state_next = ST_LINE;
                end
            end
            ST_RDATA:   state_next = ST_IDLE;
            ST_LINE:    state_next = ST_RD_L;
            ST_RD_L:    state_next = ST_RD_H;
            ST_RD_H:    state_next = ST_CALC;
            ST_CALC:    state_next = ST_WR_O;
            ST_WR_O:    state_next = (n_reg == n_last) ? ST_WR_LAST : ST_RD_L;
            ST_WR_LAST:
            begin
                if (line_reg != line_last || phase_reg != PH_V)
                begin
                    state_next = ST_LINE;
                end
                else if (lvl_reg == 2'(LEVELS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LINE;
                end
            end
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        dst_addr = ea_reg;
        dst_we   = 1'b0;
        dst_data = even_val;
        unique case (state_reg)
            ST_CALC:
            begin
                dst_we = 1'b1;
            end
            ST_WR_O:
            begin
                dst_addr = oa_reg;
                dst_we   = (n_reg != '0);
                dst_data = odd_val;
            end
            ST_WR_LAST:
            begin
                dst_addr = oa_reg;
                dst_we   = 1'b1;
                dst_data = last_val;
            end
            default:
            begin
                dst_we = 1'b0;
            end
        endcase

        tile_addr  = pos_aw;
        tile_we    = 1'b0;
        tile_wdata = coefficient;
        scr_addr   = dst_addr;
        scr_we     = 1'b0;
        scr_wdata  = dst_data;
        if (state_reg == ST_IDLE)
        begin
            tile_we = accept && opcode == OP_LOAD && pos_ok;
        end
        else if (phase_reg == PH_V)
        begin
            scr_addr   = (state_reg == ST_RD_H) ? ha_reg : la_reg;
            tile_addr  = dst_addr;
            tile_we    = dst_we;
            tile_wdata = dst_data;
        end
        else
        begin
            tile_addr = (state_reg == ST_RD_H) ? ha_reg : la_reg;
            scr_we    = dst_we;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_H1;
            lvl_reg       <= '0;
            n_reg         <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
            pos_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    pos_ok_reg <= pos_ok;
                    phase_reg  <= PH_H1;
                    lvl_reg    <= '0;
                    line_reg   <= '0;
                end
                ST_RDATA:
                begin
                    out_valid_reg <= 1'b1;
                end
                ST_LINE:
                begin
                    n_reg <= '0;
                end
                ST_WR_O:
                begin
                    if (n_reg != n_last)
                    begin
                        n_reg <= n_reg + CW'(1);
                    end
                end
                ST_WR_LAST:
                begin
                    if (line_reg != line_last)
                    begin
                        line_reg <= line_reg + CW'(1);
                    end
                    else
                    begin
                        line_reg <= '0;
                        unique case (phase_reg)
                            PH_H1:   phase_reg <= PH_H2;
                            PH_H2:   phase_reg <= PH_V;
                            default:
                            begin
                                phase_reg <= PH_H1;
                                lvl_reg   <= lvl_reg + 2'd1;
                            end
                        endcase
                    end
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    pos_ok_reg <= pos_ok_reg;
                end
            endcase
        end
    end

    // Datapath and address registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_RDATA:
            begin
                sample_reg <= pos_ok_reg ? tile_rdata : 16'd0;
                kind_reg   <= KIND_DATA;
            end
            ST_DONE:
            begin
                sample_reg <= 16'd0;
                kind_reg   <= KIND_DONE;
            end
            ST_LINE:
            begin
                unique case (phase_reg)
                    PH_H1:
                    begin
                        la_reg <= base_aw + (q_aw << 1) + q_aw + y_off;
                        ha_reg <= base_aw + y_off;
                        ea_reg <= y_off2;
                        oa_reg <= y_off2 + one_aw;
                        ls_reg <= one_aw;
                        ds_reg <= AW'(2);
                    end
                    PH_H2:
                    begin
                        la_reg <= base_aw + q_aw + y_off;
                        ha_reg <= base_aw + (q_aw << 1) + y_off;
                        ea_reg <= (q_aw << 1) + y_off2;
                        oa_reg <= (q_aw << 1) + y_off2 + one_aw;
                        ls_reg <= one_aw;
                        ds_reg <= AW'(2);
                    end
                    default:
                    begin
                        la_reg <= line_aw;
                        ha_reg <= (q_aw << 1) + line_aw;
                        ea_reg <= base_aw + line_aw;
                        oa_reg <= base_aw + tw_aw + line_aw;
                        ls_reg <= tw_aw;
                        ds_reg <= tw_aw << 1;
                    end
                endcase
            end
            ST_RD_H:
            begin
                l_reg  <= src_data;
                la_reg <= la_reg + ls_reg;
                ha_reg <= ha_reg + ls_reg;
            end
            ST_CALC:
            begin
                hprev_reg <= hcur_reg;
                hcur_reg  <= src_data;
                eprev_reg <= ecur_reg;
                ecur_reg  <= even_val;
                ea_reg    <= ea_reg + ds_reg;
            end
            ST_WR_O:
            begin
                if (n_reg != '0)
                begin
                    oa_reg <= oa_reg + ds_reg;
                end
            end
            default:
            begin
                l_reg <= l_reg;
            end
        endcase
    end

    idwt53_ram #(
        .WIDTH (16),
        .DEPTH (AREA)
    ) u_tile_ram (
        .clk   (clk),
        .addr  (tile_addr),
        .we    (tile_we),
        .wdata (tile_wdata),
        .rdata (tile_rdata)
    );

    idwt53_ram #(
        .WIDTH (16),
        .DEPTH (AREA)
    ) u_scratch_ram (
        .clk   (clk),
        .addr  (scr_addr),
        .we    (scr_we),
        .wdata (scr_wdata),
        .rdata (scr_rdata)
    );

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign kind      = kind_reg;

endmodule

/* sv/idwt53_ram.sv */
// ----------------------------------------------------------------------------
// idwt53_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module idwt53_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/idwt53_checker.sv */
// ----------------------------------------------------------------------------
// idwt53_checker
// Port-level checks on the inverse 5/3 tile transform.
// ----------------------------------------------------------------------------
module idwt53_checker
    import idwt53_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] sample,
    input logic        kind
);

    // A waiting result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A finished transform always reports a zero sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> sample == 16'd0)
        else $error("transform result carries data");

    // A read answers after passing through the read-data state into the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_READ |-> ##2 out_valid)
        else $error("read result late");

    // Taking a transform lowers in_ready; this checks the first state of the run only.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_TRANSFORM |=> !in_ready)
        else $error("input taken during transform");

endmodule

bind tile_inverse_dwt53_three_level idwt53_checker u_idwt53_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .kind      (kind)
);
